// ===== rtl/core/fir_filter_q15_circular_macros.svh =====
// assertion macros used by the port-level fir filter checker
`ifndef FIR_FILTER_Q15_CIRCULAR_MACROS_SVH
`define FIR_FILTER_Q15_CIRCULAR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define FIRQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define FIRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/firq_pkg.sv =====
// shared constants and types of the q15 fir filter
package firq_pkg;

  localparam int unsigned TAPS_DEFAULT = 61;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned COEF_W       = 16;
  localparam int unsigned TAP_IDX_W    = 6;
  localparam int unsigned PROD_W       = SAMPLE_W + COEF_W;
  localparam int unsigned RND_BIAS     = 16384;
  localparam int unsigned RND_SHIFT    = 15;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/core/fir_filter_q15_circular.sv =====
// direct-form q15 fir filter with circular delay line and coefficient memories
//
// input channel (in_valid_i / in_ready_o) takes two kinds of request: a load
// request (command 1) writes tap_value_i into the coefficient memory at
// tap_index_i, ignored when tap_index_i >= TAPS, and produces no
// result; a filter request (command 0) writes sample_i into the delay line and
// produces one filtered_o result on the output channel (out_valid_o /
// out_ready_i).
// a filter request runs one shared multiply-accumulate over the taps, one tap
// per cycle: memory read, multiply, accumulate. once the last product is
// accumulated, the result passes to the final state and is loaded into the
// output register, and in_ready_o rises with it; until then no request is taken.
// the output register holds a result while the receiver stalls; the next
// request is accepted meanwhile, and its result waits in the final state until
// the output register is free.
// reset clears the valid bits of both memories, so every coefficient and
// delay-line entry reads as zero until written, and the write position is zero.
// no clearing pass is needed after reset.
module fir_filter_q15_circular #(
  parameter int unsigned TAPS = firq_pkg::TAPS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic signed [firq_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [firq_pkg::TAP_IDX_W-1:0]      tap_index_i,
  input  logic signed [firq_pkg::COEF_W-1:0]   tap_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [firq_pkg::SAMPLE_W-1:0] filtered_o
);

  localparam int unsigned AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned CW    = $clog2(TAPS + 1);
  localparam int unsigned XW    = (CW > firq_pkg::TAP_IDX_W) ? CW : firq_pkg::TAP_IDX_W;
  localparam int unsigned ACC_W = firq_pkg::PROD_W + AW;

  localparam logic [XW-1:0]    TAPS_X = XW'(TAPS);
  localparam logic [CW-1:0]    TAPS_C = CW'(TAPS);
  localparam logic [AW-1:0]    LAST   = AW'(TAPS - 1);
  localparam logic [ACC_W-1:0] BIAS   = ACC_W'(firq_pkg::RND_BIAS);

  firq_pkg::state_e state_q, state_d;

  logic                               in_acc;
  logic                               ld_we;
  logic                               smp_we;
  logic                               rd_en;
  logic                               out_load;
  logic [XW-1:0]                      tap_x;

  logic [AW-1:0]                      wp_q;
  logic [AW-1:0]                      pos_q;
  logic [CW-1:0]                      cnt_q;
  logic                               rd_q;
  logic                               mul_q;
  logic [TAPS-1:0]                    coef_vld_q;
  logic [TAPS-1:0]                    dly_vld_q;
  logic                               coef_ok_q;
  logic                               dly_ok_q;

  logic signed [firq_pkg::COEF_W-1:0]   coef_mem [TAPS];
  logic signed [firq_pkg::SAMPLE_W-1:0] dly_mem  [TAPS];
  logic signed [firq_pkg::COEF_W-1:0]   coef_rd_q;
  logic signed [firq_pkg::SAMPLE_W-1:0] dly_rd_q;
  logic signed [firq_pkg::COEF_W-1:0]   coef_m;
  logic signed [firq_pkg::SAMPLE_W-1:0] dly_m;
  logic signed [firq_pkg::PROD_W-1:0]   prod_d;
  logic signed [firq_pkg::PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]              acc_q;
  logic [ACC_W-1:0]                     rnd;

  logic                                 out_valid_q;
  logic signed [firq_pkg::SAMPLE_W-1:0] filtered_q;

  assign tap_x  = XW'(tap_index_i);
  assign in_acc = in_valid_i && in_ready_o;
  assign ld_we  = in_acc && (command_i == firq_pkg::CMD_LOAD) && (tap_x < TAPS_X);
  assign smp_we = in_acc && (command_i == firq_pkg::CMD_FILTER);
  assign rd_en  = (state_q == firq_pkg::ST_RUN) && (cnt_q != TAPS_C);

  // state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= firq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      firq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (command_i == firq_pkg::CMD_FILTER)) begin
          state_d = firq_pkg::ST_RUN;
        end
      end
      firq_pkg::ST_RUN: begin
        if ((cnt_q == TAPS_C) && !rd_q && !mul_q) begin
          state_d = firq_pkg::ST_DONE;
        end
      end
      firq_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = firq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = firq_pkg::ST_IDLE;
      end
    endcase
  end

  // positions, tap counter and pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      pos_q      <= '0;
      cnt_q      <= '0;
      rd_q       <= 1'b0;
      mul_q      <= 1'b0;
      coef_vld_q <= '0;
      dly_vld_q  <= '0;
      coef_ok_q  <= 1'b0;
      dly_ok_q   <= 1'b0;
    end else begin
      rd_q  <= rd_en;
      mul_q <= rd_q;
      if (ld_we) begin
        coef_vld_q[tap_x[AW-1:0]] <= 1'b1;
      end
      if (smp_we) begin
        dly_vld_q[wp_q] <= 1'b1;
        pos_q           <= wp_q;
        cnt_q           <= '0;
        wp_q            <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
      end else if (rd_en) begin
        coef_ok_q <= coef_vld_q[cnt_q[AW-1:0]];
        dly_ok_q  <= dly_vld_q[pos_q];
        cnt_q     <= cnt_q + 1'b1;
        pos_q     <= (pos_q == '0) ? LAST : pos_q - 1'b1;
      end
    end
  end

  // coefficient memory
  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      coef_mem[tap_x[AW-1:0]] <= tap_value_i;
    end
    if (rd_en) begin
      coef_rd_q <= coef_mem[cnt_q[AW-1:0]];
    end
  end

  // delay-line memory
  always_ff @(posedge clk_i) begin
    if (smp_we) begin
      dly_mem[wp_q] <= sample_i;
    end
    if (rd_en) begin
      dly_rd_q <= dly_mem[pos_q];
    end
  end

  // multiply and accumulate
  assign coef_m = coef_ok_q ? coef_rd_q : '0;
  assign dly_m  = dly_ok_q ? dly_rd_q : '0;
  assign prod_d = firq_pkg::PROD_W'(coef_m) * firq_pkg::PROD_W'(dly_m);

  always_ff @(posedge clk_i) begin
    if (rd_q) begin
      prod_q <= prod_d;
    end
    if (smp_we) begin
      acc_q <= '0;
    end else if (mul_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // round, shift and keep the low bits
  assign rnd = acc_q + BIAS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filtered_q <= rnd[firq_pkg::RND_SHIFT +: firq_pkg::SAMPLE_W];
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;

endmodule

// ===== rtl/core/firq_checker.sv =====
// port-level assertions for the q15 fir filter and their binding
`include "fir_filter_q15_circular_macros.svh"

module firq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                command_i,
  input logic signed [firq_pkg::SAMPLE_W-1:0] sample_i,
  input logic [firq_pkg::TAP_IDX_W-1:0]      tap_index_i,
  input logic signed [firq_pkg::COEF_W-1:0]   tap_value_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [firq_pkg::SAMPLE_W-1:0] filtered_o
);

  logic in_acc;
  logic smp_req;
  logic ld_req;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_o;
  assign smp_req   = in_acc && (command_i == firq_pkg::CMD_FILTER);
  assign ld_req    = in_acc && (command_i == firq_pkg::CMD_LOAD);
  assign out_stall = out_valid_o && !out_ready_i;

  // result held while the receiver stalls
  `FIRQ_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o, "result dropped while stalled")
  `FIRQ_ASSERT_NEXT(a_out_stable, out_stall, $stable(filtered_o), "result changed while stalled")

  // a load request never creates a result
  `FIRQ_ASSERT_NEXT(a_load_silent, ld_req && !out_valid_o, !out_valid_o,
                    "load request produced a result")

  // a sample request occupies the datapath
  `FIRQ_ASSERT_NEXT(a_busy_after_sample, smp_req, !in_ready_o,
                    "request accepted during accumulation")

  // a result cannot appear right after a request
  `FIRQ_ASSERT_NEXT(a_no_early_result, in_acc, !$rose(out_valid_o),
                    "result appeared one cycle after a request")

endmodule

bind fir_filter_q15_circular firq_checker u_firq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .command_i   (command_i),
  .sample_i    (sample_i),
  .tap_index_i (tap_index_i),
  .tap_value_i (tap_value_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .filtered_o  (filtered_o)
);

// ===== dv/fir_filter_q15_circular_checker.sv =====
// checker of the q15 fir filter: watches both channels, predicts each result, compares
module fir_filter_q15_circular_checker #(
  parameter int unsigned TAPS = firq_pkg::TAPS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic                                 command_i,
  input  logic signed [firq_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic [firq_pkg::TAP_IDX_W-1:0]       tap_index_i,
  input  logic signed [firq_pkg::COEF_W-1:0]    tap_value_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic signed [firq_pkg::SAMPLE_W-1:0]  filtered_i,
  output int unsigned                          fail_count_o,
  output int unsigned                          pending_o,
  output int unsigned                          results_o
);

  typedef logic signed [firq_pkg::SAMPLE_W-1:0] sample_t;
  typedef logic signed [firq_pkg::COEF_W-1:0]   coef_t;

  coef_t       coef_mem [TAPS];
  sample_t     history  [TAPS];
  int unsigned write_pos;
  sample_t     filtered_q [$];
  int unsigned fail_count   = 0;
  int unsigned result_count = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    results_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic sample_t filter_sample(input sample_t s);
    longint      acc;
    int unsigned newest;
    int unsigned pos;
    history[write_pos] = s;
    newest    = write_pos;
    write_pos = (write_pos + 1 >= TAPS) ? 0 : write_pos + 1;
    acc = 0;
    for (int unsigned j = 0; j < TAPS; j++) begin
      pos = (newest >= j) ? newest - j : newest + TAPS - j;
      acc = acc + longint'(coef_mem[j]) * longint'(history[pos]);
    end
    acc = acc + longint'(firq_pkg::RND_BIAS);
    return sample_t'(acc >>> firq_pkg::RND_SHIFT);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want;
    if (!rst_ni) begin
      for (int unsigned k = 0; k < TAPS; k++) begin
        coef_mem[k] = '0;
        history[k]  = '0;
      end
      write_pos = 0;
      filtered_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no filter request outstanding",
                                    filtered_i));
        end else begin
          want = filtered_q.pop_front();
          result_count++;
          if (filtered_i !== want)
            report_mismatch($sformatf("result %0d: filtered %0d, expected %0d",
                                      result_count, filtered_i, want));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (command_i == firq_pkg::CMD_LOAD) begin
          if (tap_index_i < TAPS) coef_mem[tap_index_i] = tap_value_i;
        end else begin
          filtered_q.push_back(filter_sample(sample_i));
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= filtered_q.size();
    results_o    <= result_count;
  end

endmodule

// ===== dv/fir_filter_q15_circular_tb.sv =====
// testbench top of the q15 fir filter: clock, reset, requests, receiver and verdict
module fir_filter_q15_circular_tb;

  localparam int unsigned TAPS       = firq_pkg::TAPS_DEFAULT;
  localparam int unsigned PHASE_REQS = 578;

  typedef logic signed [firq_pkg::SAMPLE_W-1:0] sample_t;
  typedef logic [firq_pkg::TAP_IDX_W-1:0]       tap_idx_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  logic     command_i   = firq_pkg::CMD_FILTER;
  sample_t  sample_i    = '0;
  tap_idx_t tap_index_i = '0;
  sample_t  tap_value_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  sample_t  filtered_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned result_count;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned phase_idx     = 0;
  bit          hold_done     = 1'b0;
  int unsigned request_count = 0;
  int unsigned load_count    = 0;
  int unsigned ignored_count = 0;

  fir_filter_q15_circular #(
    .TAPS(TAPS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .sample_i   (sample_i),
    .tap_index_i(tap_index_i),
    .tap_value_i(tap_value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .filtered_o (filtered_o)
  );

  fir_filter_q15_circular_checker #(
    .TAPS(TAPS)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .command_i   (command_i),
    .sample_i    (sample_i),
    .tap_index_i (tap_index_i),
    .tap_value_i (tap_value_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .filtered_i  (filtered_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (result_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #(800_000 * 8);
    $display("timeout with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stalls, one long hold-off in the last phase
  initial begin
    forever begin
      @(posedge clk_i);
      if (phase_idx == 2 && !hold_done && out_valid_o) begin
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_request(input logic cmd, input sample_t smp, input tap_idx_t idx,
                              input sample_t val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    sample_i    <= smp;
    tap_index_i <= idx;
    tap_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    request_count++;
    if (cmd == firq_pkg::CMD_LOAD) begin
      load_count++;
      if (idx >= TAPS) ignored_count++;
    end
  endtask

  function automatic sample_t pick_word();
    case ($urandom_range(0, 9))
      0:       return sample_t'(-32768);
      1:       return sample_t'(32767);
      2:       return sample_t'($urandom_range(0, 1) ? 0 : -1);
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    tap_idx_t idx;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // cleared coefficients, index extremes, out of range loads, output wrap
    send_request(firq_pkg::CMD_FILTER, 16'sh7fff, '0, '0);
    send_request(firq_pkg::CMD_LOAD, '0, 6'd0, 16'sh7fff);
    send_request(firq_pkg::CMD_LOAD, '0, 6'd63, 16'sh7fff);
    send_request(firq_pkg::CMD_LOAD, '0, 6'd61, 16'sh8000);
    send_request(firq_pkg::CMD_FILTER, 16'sh8000, '1, '1);
    send_request(firq_pkg::CMD_LOAD, '0, 6'(TAPS - 1), 16'sh8000);
    send_request(firq_pkg::CMD_LOAD, '0, 6'd1, 16'sh8000);
    send_request(firq_pkg::CMD_LOAD, '0, 6'd2, 16'sh8000);
    send_request(firq_pkg::CMD_LOAD, '0, 6'd0, 16'sh8000);
    repeat (3) send_request(firq_pkg::CMD_FILTER, 16'sh8000, '0, '0);
    send_request(firq_pkg::CMD_FILTER, 16'sh7fff, '0, '0);
    send_request(firq_pkg::CMD_FILTER, 16'sh0000, '0, '0);
    send_request(firq_pkg::CMD_FILTER, 16'shffff, '0, '0);
    send_request(firq_pkg::CMD_LOAD, 16'sh7fff, 6'(TAPS - 1), 16'sh7fff);
    send_request(firq_pkg::CMD_LOAD, '0, 6'd1, 16'sh0001);
    send_request(firq_pkg::CMD_FILTER, 16'sh1234, 6'd63, 16'sh7fff);

    for (int p = 0; p < 3; p++) begin
      phase_idx     = p;
      send_idle_pct = (p == 0) ? 20 : (p == 1) ? 73 : 0;
      recv_idle_pct = (p == 0) ? 73 : (p == 1) ? 20 : 0;
      for (int n = 0; n < PHASE_REQS; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          idx = ($urandom_range(0, 6) == 0) ? tap_idx_t'($urandom_range(TAPS, 63))
                                            : tap_idx_t'($urandom_range(0, TAPS - 1));
          send_request(firq_pkg::CMD_LOAD, pick_word(), idx, pick_word());
        end else begin
          send_request(firq_pkg::CMD_FILTER, pick_word(), tap_idx_t'($urandom), pick_word());
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAPS + 8) @(posedge clk_i);

    $display("%0d requests sent: %0d coefficient loads (%0d out of range), %0d samples",
             request_count, load_count, ignored_count, request_count - load_count);
    $display("%0d filtered results checked across three stall patterns and a long hold-off",
             result_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
